// ===== src/u8d_pkg.sv =====
// Shared types and constants for the UTF-8 code point decoder.
// Depends on nothing.
package u8d_pkg;

	localparam logic [15:0] Replacement = 16'hFFFD;
	localparam int QueueDepth = 2;
	localparam int QueuePtrW = $clog2(QueueDepth);

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_word_t;

	typedef struct packed {
		logic [15:0] code_point;
		logic [1:0]  bytes_used;
		logic        is_replacement;
		logic        last_of_run;
		logic        text_done;
	} out_word_t;

	typedef struct packed {
		logic [15:0] cp;
		logic [1:0]  used;
		logic        rep;
	} res_t;

	// results of one input byte, packed from slot 0
	typedef struct packed {
		res_t [2:0] res;
		logic [1:0] count;
		logic       eot;
	} step_t;

	typedef struct packed {
		logic        stall;
		logic [15:0] cp;
		logic [1:0]  used;
		logic        rep;
	} dec_t;

endpackage

// ===== src/u8d_front.sv =====
// Front end: holds pending bytes and decodes each new byte into a step word.
// Depends on u8d_pkg.
module u8d_front (
	input  logic              clk,
	input  logic              arst_n,
	input  u8d_pkg::in_word_t text,
	input  logic              push,
	input  logic              q_full,
	output logic              full,
	output logic              q_push,
	output u8d_pkg::step_t    q_data
);

	logic [7:0] pend_q [2];
	logic [1:0] cnt_q;
	logic       accept;
	logic [7:0] rem0, rem1;
	logic [1:0] rem_avail;

	function automatic logic is_cont(input logic [7:0] b);
		return (b & 8'hC0) == 8'h80;
	endfunction

	function automatic u8d_pkg::dec_t decode(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [1:0] avail, input logic eot);
		u8d_pkg::dec_t d;
		d = '0;
		d.used = 2'd1;
		d.cp = {8'h00, b0};
		priority if (b0 < 8'h80) begin
			d.cp = {8'h00, b0};
		end else if ((b0 & 8'hE0) == 8'hC0) begin
			if (avail < 2'd2) begin
				if (eot) d.rep = 1'b1; else d.stall = 1'b1;
			end else if (is_cont(b1)) begin
				d.cp = {5'b0, b0[4:0], b1[5:0]};
				d.used = 2'd2;
			end else begin
				d.rep = 1'b1;
			end
		end else if ((b0 & 8'hF0) == 8'hE0) begin
			if (avail < 2'd2) begin
				if (eot) d.rep = 1'b1; else d.stall = 1'b1;
			end else if (!is_cont(b1)) begin
				d.rep = 1'b1;
			end else if (avail < 2'd3) begin
				if (eot) d.rep = 1'b1; else d.stall = 1'b1;
			end else if (is_cont(b2)) begin
				d.cp = {b0[3:0], b1[5:0], b2[5:0]};
				d.used = 2'd3;
			end else begin
				d.rep = 1'b1;
			end
		end else begin
			d.rep = 1'b1;
		end
		if (d.rep) begin
			d.cp = u8d_pkg::Replacement;
			d.used = 2'd1;
		end
		return d;
	endfunction

	assign full = q_full;
	assign accept = push && !q_full;

	always_comb begin
		logic [7:0]    w0, w1, w2;
		logic [1:0]    avail;
		logic          stop;
		u8d_pkg::dec_t d;
		q_data = '0;
		q_data.eot = text.end_of_text;
		stop = 1'b0;
		d = '0;
		unique case (cnt_q)
			2'd0: begin w0 = text.text_byte; w1 = 8'h00; w2 = 8'h00; end
			2'd1: begin w0 = pend_q[0]; w1 = text.text_byte; w2 = 8'h00; end
			default: begin w0 = pend_q[0]; w1 = pend_q[1]; w2 = text.text_byte; end
		endcase
		avail = (cnt_q > 2'd2) ? 2'd3 : cnt_q + 2'd1;
		for (int k = 0; k < 3; k++) begin
			if (!stop && avail != 2'd0) begin
				d = decode(w0, w1, w2, avail, text.end_of_text);
				if (d.stall) begin
					stop = 1'b1;
				end else begin
					q_data.res[k] = '{cp: d.cp, used: d.used, rep: d.rep};
					q_data.count = q_data.count + 2'd1;
					avail = avail - d.used;
					unique case (d.used)
						2'd1: begin w0 = w1; w1 = w2; w2 = 8'h00; end
						2'd2: begin w0 = w2; w1 = 8'h00; w2 = 8'h00; end
						default: begin w0 = 8'h00; w1 = 8'h00; w2 = 8'h00; end
					endcase
				end
			end
		end
		rem0 = w0;
		rem1 = w1;
		rem_avail = avail;
	end

	assign q_push = accept && (q_data.count != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (accept) begin
			cnt_q <= rem_avail;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q[0] <= rem0;
			pend_q[1] <= rem1;
		end
	end

endmodule

// ===== src/u8d_queue.sv =====
// Short queue of step words between the decoder front and the output side.
// Depends on u8d_pkg.
module u8d_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  u8d_pkg::step_t wdata,
	output logic           full,
	input  logic           pop,
	output u8d_pkg::step_t head,
	output logic           empty
);

	u8d_pkg::step_t                   mem_q [u8d_pkg::QueueDepth];
	logic [u8d_pkg::QueuePtrW-1:0]    wr_q, rd_q;
	logic [u8d_pkg::QueuePtrW:0]      cnt_q;
	logic                             do_push, do_pop;

	assign full    = cnt_q == (u8d_pkg::QueuePtrW+1)'(u8d_pkg::QueueDepth);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	function automatic logic [u8d_pkg::QueuePtrW-1:0] next_ptr(
			input logic [u8d_pkg::QueuePtrW-1:0] p);
		return (p == u8d_pkg::QueuePtrW'(u8d_pkg::QueueDepth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= next_ptr(wr_q);
			if (do_pop) rd_q <= next_ptr(rd_q);
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

// ===== src/u8d_back.sv =====
// Output side: walks the results of the head step word, one word per pop.
// Depends on u8d_pkg.
module u8d_back (
	input  logic               clk,
	input  logic               arst_n,
	input  u8d_pkg::step_t     head,
	input  logic               q_empty,
	output logic               q_pop,
	input  logic               pop,
	output u8d_pkg::out_word_t decoded
);

	logic [1:0]    idx_q;
	logic          last;
	u8d_pkg::res_t cur;

	assign cur   = head.res[idx_q];
	assign last  = idx_q == head.count - 2'd1;
	assign q_pop = pop && !q_empty && last;

	always_comb begin
		decoded.code_point     = cur.cp;
		decoded.bytes_used     = cur.used;
		decoded.is_replacement = cur.rep;
		decoded.last_of_run    = last;
		decoded.text_done      = last && head.eot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (pop && !q_empty) begin
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

// ===== src/utf8_codepoint_decoder_unit.sv =====
// UTF-8 decoder, one to three byte forms. Takes one byte a cycle while the
// step queue is not full; the results of a byte are registered in the queue
// before they reach the output. Results leave one word a cycle while pop is
// held; a step word leaves the two-entry queue with its last result, and
// the queue lets input continue meanwhile. Reset clears the pending byte
// count and the queue. Depends on u8d_pkg, u8d_front, u8d_queue, u8d_back.
module utf8_codepoint_decoder_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  u8d_pkg::in_word_t  text,
	input  logic               pop,
	output logic               empty,
	output u8d_pkg::out_word_t decoded
);

	logic           q_push, q_full, q_pop;
	u8d_pkg::step_t q_wdata, q_head;

	u8d_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.push   (push),
		.q_full (q_full),
		.full   (full),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	u8d_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.head   (q_head),
		.empty  (empty)
	);

	u8d_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (q_head),
		.q_empty (empty),
		.q_pop   (q_pop),
		.pop     (pop),
		.decoded (decoded)
	);

endmodule
